>>> hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file in hdl imports this package.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int PRIO_W      = 16;
    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 5;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_JUMP   = 2'd2,
        MODE_QUERY  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] data;
    } entry_t;

    // Broadcast from the control logic to every cell in the chain.
    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/spq_if.sv
// Request and response channel interfaces of the sorted priority queue.
// Depends on spq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface spq_req_if import spq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [PRIO_W-1:0] priority_req;
    logic signed [DATA_W-1:0] data_in;

    modport source (output valid, output mode, output priority_req, output data_in,
                    input ready);
    modport sink   (input valid, input mode, input priority_req, input data_in,
                    output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] removed_data;
    logic [COUNT_OUT_W-1:0]   count;
    logic signed [DATA_W-1:0] head_data;
    logic signed [DATA_W-1:0] middle_data;
    logic signed [DATA_W-1:0] last_data;

    modport source (output valid, output status, output removed_data, output count,
                    output head_data, output middle_data, output last_data,
                    input ready);
    modport sink   (input valid, input status, input removed_data, input count,
                    input head_data, input middle_data, input last_data,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on spq_pkg for the entry and control types.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell import spq_pkg::*; #(
    parameter int IDX     = 0,
    parameter int COUNT_W = 5
) (
    input  wire logic               clk,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic [COUNT_W-1:0] count,
    input  wire logic               left_gt,
    input  wire entry_t             left_entry,
    input  wire entry_t             right_entry,
    output entry_t                  entry,
    output logic                    gt,
    output logic                    sel_mid,
    output logic                    sel_last
);

    localparam logic [COUNT_W-1:0] IDX_C = COUNT_W'(IDX);

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;
    logic   at_end;

    assign occupied = IDX_C < count;
    assign at_end   = IDX_C == count;
    assign gt       = occupied && (entry_reg.prio > ctrl.new_entry.prio);
    assign sel_mid  = (count != '0) && (IDX_C == (count >> 1));
    assign sel_last = (count != '0) && (IDX_C == (count - 1'b1));
    assign entry    = entry_reg;

    // Entries that sort after the new one move right by one; the new entry
    // lands in the first slot that is greater or past the end.
    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (left_gt)
                begin
                    entry_next = left_entry;
                end
                else if (gt || at_end)
                begin
                    entry_next = ctrl.new_entry;
                end
            end
            CELL_REMOVE:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

>>> hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: control, cell chain and response register.
// Depends on spq_pkg, spq_if (spq_req_if, spq_rsp_if) and spq_cell.
//
//   channel | modport          | moves
//   --------+------------------+-----------------------------------------------
//   req     | spq_req_if.sink  | mode, priority_req, data_in
//   rsp     | spq_rsp_if.source| status, removed_data, count, head/middle/last
//
// One request is taken per cycle when the response side keeps up. The cell
// chain updates at the edge that accepts a request; the response waits in the
// pending slot and is loaded into the output register when that register is free.
// The single pending-response slot in front of the output register sets the rate:
// a request is refused only while a pending response cannot move on.
// Reset (rst_n, asynchronous, active low) clears the count and handshake state;
// entry contents are not cleared and are never read beyond the count.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue import spq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

    // Cell chain wiring; each element belongs to one cell.
    entry_t cell_entry [DEPTH];
    logic   cell_gt    [DEPTH];
    logic   cell_mid   [DEPTH];
    logic   cell_last  [DEPTH];

    cell_ctrl_t ctrl;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               pend_reg;
    status_t            status_reg;
    status_t            status_next;
    logic signed [DATA_W-1:0] removed_reg;
    logic signed [DATA_W-1:0] removed_next;

    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic signed [DATA_W-1:0] out_removed_reg;
    logic [COUNT_OUT_W-1:0]   out_count_reg;
    logic signed [DATA_W-1:0] out_head_reg;
    logic signed [DATA_W-1:0] out_mid_reg;
    logic signed [DATA_W-1:0] out_last_reg;

    logic                     out_free;
    logic                     out_load;
    logic                     req_accept;
    logic signed [DATA_W-1:0] mid_sel;
    logic signed [DATA_W-1:0] last_sel;
    logic signed [PRIO_W-1:0] jump_prio;
    cell_op_t                 op_sel;
    logic                     empty;
    logic                     full;

    // The pending slot may be refilled in the same cycle that it drains,
    // since the response reads the chain before the edge that updates it.
    assign out_free   = !out_valid_reg || rsp.ready;
    assign out_load   = pend_reg && out_free;
    assign req.ready  = !pend_reg || out_free;
    assign req_accept = req.valid && req.ready;

    assign empty = count_reg == '0;
    assign full  = count_reg == DEPTH_C;

    // Jump ahead takes one below the head's priority, saturating at the minimum.
    assign jump_prio = (cell_entry[0].prio == PRIO_MIN) ? PRIO_MIN
                                                        : cell_entry[0].prio - PRIO_W'(1);

    always_comb
    begin
        op_sel       = CELL_HOLD;
        status_next  = STATUS_OK;
        removed_next = '0;
        count_next   = count_reg;
        ctrl.new_entry.prio = req.priority_req;
        ctrl.new_entry.data = req.data_in;
        case (mode_t'(req.mode))
            MODE_INSERT:
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    op_sel     = CELL_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_REMOVE:
            begin
                if (empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    op_sel       = CELL_REMOVE;
                    removed_next = cell_entry[0].data;
                    count_next   = count_reg - 1'b1;
                end
            end
            MODE_JUMP:
            begin
                ctrl.new_entry.prio = jump_prio;
                if (empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    op_sel     = CELL_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                op_sel = CELL_HOLD;
            end
        endcase
        ctrl.op = req_accept ? op_sel : CELL_HOLD;
    end

    // The chain: each cell sees its left neighbor for inserts and its right
    // neighbor for removals. The last cell refills from itself on removal,
    // which is harmless since it falls outside the count.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic   left_gt;
        entry_t left_entry;
        entry_t right_entry;

        if (i == 0)
        begin : g_first
            assign left_gt    = 1'b0;
            assign left_entry = cell_entry[0];
        end
        else
        begin : g_inner
            assign left_gt    = cell_gt[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        spq_cell #(
            .IDX     (i),
            .COUNT_W (COUNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left_gt     (left_gt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i]),
            .sel_mid     (cell_mid[i]),
            .sel_last    (cell_last[i])
        );
    end

    // Each cell flags whether it is the middle or last slot; at most one cell
    // raises each flag, so an OR of the flagged data picks it out.
    always_comb
    begin
        mid_sel  = '0;
        last_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            mid_sel  = mid_sel  | (cell_mid[i]  ? cell_entry[i].data : '0);
            last_sel = last_sel | (cell_last[i] ? cell_entry[i].data : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_accept)
            begin
                count_reg <= count_next;
            end

            if (req_accept)
            begin
                pend_reg <= 1'b1;
            end
            else if (out_load)
            begin
                pend_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
        end
        if (out_load)
        begin
            out_status_reg  <= status_reg;
            out_removed_reg <= removed_reg;
            out_count_reg   <= COUNT_OUT_W'(count_reg);
            out_head_reg    <= empty ? '0 : cell_entry[0].data;
            out_mid_reg     <= mid_sel;
            out_last_reg    <= last_sel;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.removed_data = out_removed_reg;
    assign rsp.count        = out_count_reg;
    assign rsp.head_data    = out_head_reg;
    assign rsp.middle_data  = out_mid_reg;
    assign rsp.last_data    = out_last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count exceeds depth");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && (req.mode == MODE_REMOVE) && !empty)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("remove did not decrement count");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && full && (req.mode == MODE_INSERT)) |=> (count_reg == DEPTH_C))
        else $error("insert into full queue changed count");

    a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !out_free) |=> pend_reg)
        else $error("pending response lost while output stalled");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> rsp.valid)
        else $error("loaded response not presented");
`endif

endmodule

`default_nettype wire
